>>> hdl/multichannel_oneshot_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shorthand for the concurrent checks used inside the timer bank RTL. The
// including module must provide clk and rst.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_ONESHOT_TIMER_BANK_MACROS_SVH
`define MULTICHANNEL_ONESHOT_TIMER_BANK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MOTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MOTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/motb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Request and result types, command codes, sizes and register constants
// shared by the one-shot timer bank files.
// ----------------------------------------------------------------------------
package motb_pkg;

  // Bank size. The request and result fields below are sized for these.
  localparam int unsigned CHANNELS    = 256;
  localparam int unsigned GROUP_WIDTH = 32;

  // Command codes carried in the mode field of a request.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Register map: the register index is the word address.
  localparam int unsigned PADDR_W          = 3;
  localparam logic        REG_TIME_SCALE   = 1'b0;
  localparam logic        REG_CHECK_PERIOD = 1'b1;

  localparam logic [15:0] TIME_SCALE_RESET   = 16'd1;
  localparam logic [15:0] CHECK_PERIOD_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  channel;
    logic [15:0] duration;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  group;
    logic [31:0] toggle_mask;
    logic [31:0] status_mask;
    logic        last;
  } res_t;

endpackage

>>> hdl/motb_ram.sv
// ----------------------------------------------------------------------------
// Timer bank RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module motb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/multichannel_oneshot_timer_bank.sv
// ----------------------------------------------------------------------------
// Multichannel one-shot timer bank
// Per-channel one-shot relay timers on a tick-driven millisecond counter,
// with periodic expiry scans reported as per-group toggle and status masks.
// ----------------------------------------------------------------------------
// Usage. Requests enter on cmd (cmd_valid/cmd_stall): start arms a channel
// and toggles its relay at once, stop disarms it, tick advances the
// millisecond counter. Results leave on res (res_valid/res_stall), one
// result per reported channel group, with last set on the final result of
// a request. The block takes one request at a time and holds cmd_stall high
// until that request is finished.
// Steps: a start arms its channel and writes its end time, a stop disarms
// it, then the result is registered in the output register. A tick without
// a scan only checks whether a scan is due. A tick that triggers a scan
// reads one stored end time per cycle while not paused, from the end-time
// RAM through its single read port, and compares it on the shared
// comparator. Ticks are expected once per millisecond.
// Reset (synchronous, rst high) clears the counters and disarms every
// channel; the end-time RAM needs no clearing since an end time is only
// looked at while its channel is armed. When the receiver stalls, the
// result stays in the output register; a scan that needs to hand over a
// further result pauses until the output register frees up.
// ----------------------------------------------------------------------------
`include "multichannel_oneshot_timer_bank_macros.svh"

module multichannel_oneshot_timer_bank import motb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Request channel.
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  // Result channel.
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned GW      = GROUP_WIDTH;
  localparam int unsigned NGROUPS = (CHANNELS + GW - 1) / GW;
  localparam int unsigned IW      = $clog2(CHANNELS);
  localparam int unsigned BW      = $clog2(GW);
  localparam int unsigned GIW     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int unsigned EN_W    = NGROUPS * GW;
  localparam int unsigned EIW     = $clog2(EN_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_RESP,
    ST_TICK,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;

  // Configuration and time base.
  logic [15:0] time_scale;
  logic [15:0] check_period;
  logic [31:0] now;
  logic [31:0] last_check;

  // Arm bits, padded to whole groups; the pad bits are never set.
  logic [EN_W-1:0] enabled;

  // Request being worked on.
  logic [1:0]  item_mode;
  logic [8:0]  item_idx;
  logic [31:0] span;

  // Scan pipeline: read issue side and compare side.
  logic [IW-1:0]  rd_idx;
  logic [BW-1:0]  rd_bit;
  logic [GIW-1:0] rd_grp;
  logic           rd_more;
  logic           chk_valid;
  logic [IW-1:0]  chk_idx;
  logic [BW-1:0]  chk_bit;
  logic [GIW-1:0] chk_grp;
  logic [GW-1:0]  tog_acc;

  // One group result held back until we know whether it is the last one.
  logic           pend_valid;
  logic [GIW-1:0] pend_grp;
  logic [GW-1:0]  pend_tog;
  logic [GW-1:0]  pend_status;

  // Combinational signals.
  logic           out_free;
  logic [GIW-1:0] item_grp;
  logic [BW-1:0]  item_bit;
  logic [31:0]    cmp_a;
  logic [31:0]    cmp_b;
  logic           cmp_gt;
  logic           hit;
  logic [GW-1:0]  hit_mask;
  logic [GW-1:0]  tog_now;
  logic           chk_last;
  logic           group_end;
  logic [GIW-1:0] grp_sel;
  logic [GW-1:0]  status_sel;
  logic [GW-1:0]  g_status;
  logic           scan_stall;
  logic           push;
  res_t           push_res;
  logic           chan_bad;
  logic           ram_we;
  logic [IW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;

  motb_ram #(
    .WIDTH (32),
    .DEPTH (CHANNELS)
  ) u_end_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(item_idx)),
    .wdata (now + span),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_stall = (state != ST_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CHECK_PERIOD) ? {16'd0, check_period}
                                                    : {16'd0, time_scale};
  assign chan_bad  = (cmd.channel == 9'd0) || (32'(cmd.channel) > 32'(CHANNELS));
  assign out_free  = !res_valid || !res_stall;
  // The group width is a power of two, so the group and bit of a channel
  // are plain slices of its index.
  assign item_grp  = GIW'(item_idx >> BW);
  assign item_bit  = item_idx[BW-1:0];

  always_comb begin
    // The one comparator is shared by the scan-due check and the
    // per-channel expiry check.
    cmp_a = '0;
    cmp_b = '0;
    unique case (state)
      ST_TICK: begin
        cmp_a = now - last_check;
        cmp_b = 32'(check_period);
      end
      ST_SCAN: begin
        cmp_a = now;
        cmp_b = ram_rdata;
      end
      default: begin
      end
    endcase
    cmp_gt = (cmp_a > cmp_b);

    hit       = (state == ST_SCAN) && chk_valid && enabled[EIW'(chk_idx)] && cmp_gt;
    hit_mask  = hit ? (GW'(1) << chk_bit) : '0;
    tog_now   = tog_acc | hit_mask;
    chk_last  = (chk_idx == IW'(CHANNELS - 1));
    group_end = chk_valid && ((chk_bit == BW'(GW - 1)) || chk_last);

    grp_sel    = (state == ST_SCAN) ? chk_grp : item_grp;
    status_sel = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      if (grp_sel == GIW'(g)) begin
        status_sel = enabled[g * GW +: GW];
      end
    end
    g_status = status_sel & ~hit_mask;

    scan_stall = (state == ST_SCAN) && group_end && (tog_now != '0) && pend_valid &&
                 !out_free;

    push     = 1'b0;
    push_res = '0;
    unique case (state)
      ST_RESP: begin
        push                 = out_free;
        push_res.group       = 3'(item_grp);
        push_res.toggle_mask = (item_mode == MODE_START) ? 32'(GW'(1) << item_bit) : '0;
        push_res.status_mask = 32'(status_sel);
        push_res.last        = 1'b1;
      end
      ST_SCAN: begin
        push                 = group_end && (tog_now != '0) && pend_valid && out_free;
        push_res.group       = 3'(pend_grp);
        push_res.toggle_mask = 32'(pend_tog);
        push_res.status_mask = 32'(pend_status);
        push_res.last        = 1'b0;
      end
      ST_FLUSH: begin
        push                 = pend_valid && out_free;
        push_res.group       = 3'(pend_grp);
        push_res.toggle_mask = 32'(pend_tog);
        push_res.status_mask = 32'(pend_status);
        push_res.last        = 1'b1;
      end
      default: begin
      end
    endcase

    ram_we    = (state == ST_APPLY) && (item_mode == MODE_START);
    // While paused, keep reading the entry under compare so its data holds.
    ram_raddr = scan_stall ? chk_idx : rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      time_scale   <= TIME_SCALE_RESET;
      check_period <= CHECK_PERIOD_RESET;
      now          <= '0;
      last_check   <= '0;
      enabled      <= '0;
      res_valid    <= 1'b0;
      rd_more      <= 1'b0;
      chk_valid    <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_TIME_SCALE:   time_scale   <= pwdata[15:0];
          REG_CHECK_PERIOD: check_period <= pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (push) begin
        res_valid <= 1'b1;
        res       <= push_res;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            item_mode <= cmd.mode;
            item_idx  <= cmd.channel - 9'd1;
            // The timer length is registered here so the end-time write
            // only needs one adder.
            span      <= 32'(cmd.duration) * 32'(time_scale);
            unique case (cmd.mode)
              MODE_START, MODE_STOP: begin
                if (!chan_bad) begin
                  state <= ST_APPLY;
                end
              end
              MODE_TICK: begin
                now   <= now + 32'd1;
                state <= ST_TICK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_APPLY: begin
          enabled[EIW'(item_idx)] <= (item_mode == MODE_START);
          state                   <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (cmp_gt) begin
            state      <= ST_SCAN;
            rd_idx     <= '0;
            rd_bit     <= '0;
            rd_grp     <= '0;
            rd_more    <= 1'b1;
            chk_valid  <= 1'b0;
            tog_acc    <= '0;
            pend_valid <= 1'b0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!scan_stall) begin
            if (hit) begin
              enabled[EIW'(chk_idx)] <= 1'b0;
            end
            // After the final channel has been issued, rd_more is low, so
            // the compare side drains on its own.
            chk_valid <= rd_more;
            chk_idx   <= rd_idx;
            chk_bit   <= rd_bit;
            chk_grp   <= rd_grp;
            if (rd_more) begin
              if (rd_idx == IW'(CHANNELS - 1)) begin
                rd_more <= 1'b0;
              end else begin
                rd_idx <= rd_idx + IW'(1);
              end
              if (rd_bit == BW'(GW - 1)) begin
                rd_bit <= '0;
                rd_grp <= rd_grp + GIW'(1);
              end else begin
                rd_bit <= rd_bit + BW'(1);
              end
            end
            if (group_end) begin
              tog_acc <= '0;
              if (tog_now != '0) begin
                pend_valid  <= 1'b1;
                pend_grp    <= chk_grp;
                pend_tog    <= tog_now;
                pend_status <= g_status;
              end
            end else begin
              tog_acc <= tog_now;
            end
            if (chk_valid && chk_last) begin
              last_check <= now;
              state      <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result that is not the last of its request comes from a scan, where
  // every toggled channel has just been disarmed.
  `MOTB_ASSERT_NOW(a_scan_tog_disarmed, res_valid && !res.last, (res.toggle_mask & res.status_mask) == 32'd0, "scan result reports a toggled channel as armed")
  // A tick request advances the millisecond counter by exactly one.
  `MOTB_ASSERT_NEXT(a_tick_advances, cmd_valid && !cmd_stall && cmd.mode == MODE_TICK, now == $past(now) + 32'd1, "tick did not advance the counter")
  // The scan never runs dry before its final channel has been compared.
  `MOTB_ASSERT_NOW(a_scan_progress, state == ST_SCAN, rd_more || chk_valid, "scan lost track of its channel")
  // A held-back group result always carries at least one toggle.
  `MOTB_ASSERT_NOW(a_pend_nonempty, pend_valid, pend_tog != '0, "pending group result has no toggle")

endmodule

>>> bench/multichannel_oneshot_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives start, stop and tick requests into the one-shot timer bank under
// several time_scale and check_period settings, with random idle cycles on
// both channels. A cycle-free software copy of the bank predicts each
// result, and every result is checked field by field in order. Register
// writes are read back over the configuration port.
// ----------------------------------------------------------------------------
module multichannel_oneshot_timer_bank_tb;
  import motb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_CH     = 256;
  localparam int unsigned GRP_W    = 32;
  localparam int unsigned N_GRP    = N_CH / GRP_W;
  // The fourth mode code has no meaning; the bank must ignore it.
  localparam logic [1:0]  MODE_VOID = 2'd3;
  // A scan walks every channel, so a tick may keep the bank busy this long
  // without producing any result.
  localparam int unsigned QUIET_CYCLES = N_CH + 44;
  localparam int unsigned MAX_LINES    = 60;

  logic               clk = 1'b0;
  logic               rst;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_t               cmd = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_t               res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  multichannel_oneshot_timer_bank u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Software copy of the bank: clock, last scan time, per-channel arm bits
  // and deadlines, plus the two registers.
  logic [15:0] scale_reg  = TIME_SCALE_RESET;
  logic [15:0] period_reg = CHECK_PERIOD_RESET;
  logic [31:0] clock_ms   = '0;
  logic [31:0] scanned_ms = '0;
  logic        armed    [N_CH];
  logic [31:0] deadline [N_CH];

  // Requests waiting to be driven, and the relay reports the bank owes us.
  cmd_t        cmd_backlog[$];
  res_t        relay_reports[$];
  int unsigned mismatches = 0;

  // Handshake bookkeeping; the took flags record the last rising edge.
  logic        cmd_took   = 1'b0;
  logic        res_took   = 1'b0;
  int unsigned cmd_gap    = 0;
  int unsigned res_wait   = 0;
  logic        cmd_steady = 1'b0;
  logic        res_steady = 1'b0;

  initial begin
    foreach (armed[i]) begin
      armed[i]    = 1'b0;
      deadline[i] = '0;
    end
  end

  function automatic logic [31:0] group_status(int unsigned grp);
    logic [31:0] m;
    m = '0;
    for (int unsigned b = 0; b < GRP_W; b++) begin
      m[b] = armed[grp * GRP_W + b];
    end
    return m;
  endfunction

  // Applies one request to the software copy and queues the reports that
  // it owes: one for a start or stop on a channel within the bank, one per
  // group with an expiry for a tick that triggers a scan.
  function automatic void advance_bank(cmd_t r);
    int unsigned idx;
    int          hits;
    int          k;
    logic [31:0] togs [N_GRP];
    res_t        o;
    o = '0;
    case (r.mode)
      MODE_START, MODE_STOP: begin
        if (r.channel == 0 || r.channel > N_CH) begin
          return;
        end
        idx = r.channel - 1;
        if (r.mode == MODE_START) begin
          // A restart of an armed channel toggles again with a new deadline.
          armed[idx]    = 1'b1;
          deadline[idx] = clock_ms + 32'(r.duration) * 32'(scale_reg);
          o.toggle_mask[idx % GRP_W] = 1'b1;
        end else begin
          armed[idx] = 1'b0;
        end
        o.group       = 3'(idx / GRP_W);
        o.status_mask = group_status(idx / GRP_W);
        o.last        = 1'b1;
        relay_reports.push_back(o);
      end
      MODE_TICK: begin
        clock_ms = clock_ms + 1;
        if (clock_ms - scanned_ms <= period_reg) begin
          return;
        end
        foreach (togs[g]) begin
          togs[g] = '0;
        end
        for (int unsigned i = 0; i < N_CH; i++) begin
          if (armed[i] && deadline[i] < clock_ms) begin
            armed[i] = 1'b0;
            togs[i / GRP_W][i % GRP_W] = 1'b1;
          end
        end
        scanned_ms = clock_ms;
        hits = 0;
        foreach (togs[g]) begin
          if (togs[g] != 0) hits++;
        end
        k = 0;
        for (int unsigned g = 0; g < N_GRP; g++) begin
          if (togs[g] != 0) begin
            o.group       = 3'(g);
            o.toggle_mask = togs[g];
            o.status_mask = group_status(g);
            o.last        = (k == hits - 1);
            relay_reports.push_back(o);
            k++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_LINES) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    cmd_took <= !rst && cmd_valid && !cmd_stall;
    res_took <= !rst && res_valid && !res_stall;
  end

  // Request driver. A new request goes out only once the previous one has
  // been taken and its idle gap has run out; the payload holds while the
  // bank stalls. Prediction happens as the request leaves the backlog,
  // which keeps the report order equal to the request order.
  always @(negedge clk) begin : request_driver
    cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_took) begin
      if (cmd_gap != 0) begin
        cmd_valid <= 1'b0;
        cmd_gap   <= cmd_gap - 1;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        advance_bank(nxt);
        cmd       <= nxt;
        cmd_valid <= 1'b1;
        // Now and then switch between back-to-back requests and random gaps.
        if ($urandom_range(0, 15) == 0) cmd_steady <= !cmd_steady;
        cmd_gap   <= cmd_steady ? 0 : $urandom_range(0, 4);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result stall. After each report taken, hold off for a fresh random
  // number of cycles, except during stretches of full-rate draining.
  always @(negedge clk) begin : report_stall
    int unsigned n;
    if (rst) begin
      res_stall <= 1'b0;
      res_wait  <= 0;
    end else begin
      if (res_took) begin
        if ($urandom_range(0, 15) == 0) res_steady <= !res_steady;
        n = res_steady ? 0 : $urandom_range(0, 4);
      end else begin
        n = res_wait;
      end
      if (n != 0) begin
        res_stall <= 1'b1;
        res_wait  <= n - 1;
      end else begin
        res_stall <= 1'b0;
        res_wait  <= 0;
      end
    end
  end

  // Report checker: every report taken must match the oldest one owed.
  always @(posedge clk) begin : report_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (relay_reports.size() == 0) begin
        flag_mismatch($sformatf("report with none owed: group %0d toggle %h status %h",
                                res.group, res.toggle_mask, res.status_mask));
      end else begin
        want = relay_reports.pop_front();
        if (res.group !== want.group)
          flag_mismatch($sformatf("group %0d, owed %0d", res.group, want.group));
        if (res.toggle_mask !== want.toggle_mask)
          flag_mismatch($sformatf("group %0d toggle_mask %h, owed %h",
                                  want.group, res.toggle_mask, want.toggle_mask));
        if (res.status_mask !== want.status_mask)
          flag_mismatch($sformatf("group %0d status_mask %h, owed %h",
                                  want.group, res.status_mask, want.status_mask));
        if (res.last !== want.last)
          flag_mismatch($sformatf("group %0d last %b, owed %b",
                                  want.group, res.last, want.last));
      end
    end
  end

  // One write over the configuration port, followed by a read back of the
  // same register. The bank must be idle when this runs.
  task automatic set_register(logic addr_bit, logic [15:0] value);
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr_bit, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr_bit == REG_TIME_SCALE) begin
      scale_reg = value;
    end else begin
      period_reg = value;
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== {16'h0000, value})
      flag_mismatch($sformatf("register %0d reads %h, written %h", addr_bit, got, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_bank(logic [15:0] scale, logic [15:0] period);
    set_register(REG_TIME_SCALE, scale);
    set_register(REG_CHECK_PERIOD, period);
  endtask

  function automatic void queue_request(logic [1:0] mode, logic [8:0] ch, logic [15:0] dur);
    cmd_t r;
    r.mode     = mode;
    r.channel  = ch;
    r.duration = dur;
    cmd_backlog.push_back(r);
  endfunction

  // Random requests: half of them ticks, mixed in with starts and fewer stops
  // on a crowded low range of channels with mostly short durations, and a
  // little noise that the bank must ignore.
  function automatic void queue_random(int unsigned count);
    int unsigned pick;
    logic [8:0]  ch;
    logic [15:0] dur;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ch   = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 64))
                                         : 9'($urandom_range(1, N_CH));
      case ($urandom_range(0, 6))
        0, 1, 2, 3: dur = 16'($urandom_range(0, 12));
        4, 5:       dur = 16'($urandom_range(0, 200));
        default:    dur = 16'($urandom_range(0, 65535));
      endcase
      if (pick < 35) begin
        queue_request(MODE_START, ch, dur);
      end else if (pick < 45) begin
        queue_request(MODE_STOP, ch, dur);
      end else if (pick < 95) begin
        queue_request(MODE_TICK, 9'($urandom_range(0, 511)),
                      16'($urandom_range(0, 65535)));
      end else if (pick < 97) begin
        queue_request(MODE_VOID, 9'($urandom_range(0, 511)), dur);
      end else begin
        ch = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(N_CH + 1, 511));
        queue_request($urandom_range(0, 1) ? MODE_START : MODE_STOP, ch, dur);
      end
    end
  endfunction

  // Waits until every request has gone out and every report has come back,
  // then lets a full scan's worth of cycles pass in case the last tick
  // started a scan that expired nothing.
  task automatic settle();
    while (!(cmd_backlog.size() == 0 && !cmd_valid && relay_reports.size() == 0))
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] scale, logic [15:0] period, int unsigned count);
    program_bank(scale, period);
    queue_random(count);
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: scan every third tick at one millisecond per unit.
    program_bank(16'd1, 16'd2);
    // A zero duration sets the deadline to now; it expires on the next scan.
    queue_request(MODE_START, 9'd1, 16'd0);
    queue_request(MODE_START, 9'd256, 16'hFFFF);
    queue_request(MODE_START, 9'd32, 16'd3);
    queue_request(MODE_START, 9'd33, 16'd1);
    // Channel zero, channels past the bank and the unused mode do nothing.
    queue_request(MODE_START, 9'd0, 16'd5);
    queue_request(MODE_START, 9'd257, 16'd5);
    queue_request(MODE_STOP, 9'h1FF, 16'hFFFF);
    queue_request(MODE_VOID, 9'd5, 16'hFFFF);
    // A stop of an idle channel still reports its group.
    queue_request(MODE_STOP, 9'd100, 16'd0);
    // Restart of an armed channel: it toggles again and takes the new deadline.
    queue_request(MODE_START, 9'd200, 16'd40);
    queue_request(MODE_START, 9'd200, 16'd2);
    queue_request(MODE_STOP, 9'd256, 16'd0);
    repeat (8) queue_request(MODE_TICK, 9'd0, 16'd0);
    // Expiries spread over several groups in one scan.
    queue_request(MODE_START, 9'd129, 16'd0);
    queue_request(MODE_START, 9'd160, 16'd0);
    queue_request(MODE_START, 9'd161, 16'd0);
    queue_request(MODE_START, 9'd224, 16'd1);
    repeat (5) queue_request(MODE_TICK, 9'h1FF, 16'hFFFF);
    settle();

    // Random part over a spread of settings, the extremes among them.
    run_phase(16'd60000, 16'd65535, 43);
    run_phase(16'd0,     16'd0,     43);
    run_phase(16'd1,     16'd5,     43);
    run_phase(16'd3,     16'd1,     43);
    run_phase(16'd65535, 16'd12,    43);
    run_phase(16'd2,     16'd10,    43);
    run_phase(16'd1,     16'd30,    43);
    run_phase(16'd1,     16'd0,     43);

    if (mismatches == 0 && relay_reports.size() == 0) begin
      $display("multichannel_oneshot_timer_bank test passed");
    end else begin
      $display("multichannel_oneshot_timer_bank test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("multichannel_oneshot_timer_bank test failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/motb_pkg.sv
hdl/motb_ram.sv
hdl/multichannel_oneshot_timer_bank.sv
bench/multichannel_oneshot_timer_bank_tb.sv
